@@ src/extent_read_router_core_macros.svh @@
// Assertion macros for the extent read router.
// Used by the modules in src that carry concurrent checks.
`ifndef EXTENT_READ_ROUTER_CORE_MACROS_SVH
`define EXTENT_READ_ROUTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ERC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ERC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ERC_ASSERT(lbl, clk, rstn, prop, msg)
`define ERC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ src/erc_pkg.sv @@
// Shared types and constants of the extent read router.
// No dependencies.
package erc_pkg;
    localparam int MAX_EXTENTS     = 64;
    localparam int PAGE_SHIFT_BITS = 12;
    localparam int SECTOR_SHIFT    = 9;
    localparam int PAGE_SHIFT      = PAGE_SHIFT_BITS - SECTOR_SHIFT;
    localparam int CNT_W           = $clog2(MAX_EXTENTS + 1);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [2:0] ST_COPY_SOURCE = 3'd1;
    localparam logic [2:0] ST_INVALID     = 3'd2;
    localparam logic [2:0] ST_NONE        = 3'd3;
    localparam logic [2:0] ST_NEEDS_INIT  = 3'd4;

    localparam logic [2:0] ROUTE_FALLBACK = 3'd0;
    localparam logic [2:0] ROUTE_ZERO     = 3'd1;
    localparam logic [2:0] ROUTE_DEVICE   = 3'd2;
    localparam logic [2:0] ROUTE_DONE     = 3'd3;
    localparam logic [2:0] ROUTE_FULL     = 3'd4;

    typedef struct packed {
        logic [53:0] start;
        logic [53:0] len;
        logic [53:0] vol;
        logic [2:0]  state;
        logic [31:0] init_map;
    } ext_t;

    // Lookup request as it travels along the chain of cells.
    typedef struct packed {
        logic        valid;
        logic        stop;
        logic        have_main;
        logic        have_cow;
        logic [53:0] sect;
        logic [32:0] cnt;
        ext_t        main;
        logic [53:0] cow_start;
        logic [53:0] cow_vol;
    } token_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  route;
        logic [63:0] dev;
    } result_t;
endpackage

@@ src/erc_cell.sv @@
// One extent cell of the router chain: holds one table entry and
// updates the passing lookup request. Depends on erc_pkg.
module erc_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [erc_pkg::CNT_W-1:0] idx,
    input  logic [erc_pkg::CNT_W-1:0] count,
    input  logic                     wr_en,
    input  erc_pkg::ext_t            wr_ext,
    input  erc_pkg::token_t          tok_in,
    output erc_pkg::token_t          tok_out
);
    import erc_pkg::*;

    ext_t   ext_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   in_range;

    assign in_range = idx < count;
    assign tok_out  = tok_reg;

    // Entry storage, written when the append lands on this cell.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ext_reg <= wr_ext;
        end
    end

    // Walk step: stop past the sector, take up to two covering extents.
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.stop && in_range) begin
            if (tok_in.sect < ext_reg.start) begin
                tok_next.stop = 1'b1;
            end else if ({1'b0, tok_in.sect} < ({1'b0, ext_reg.start} + {1'b0, ext_reg.len})) begin
                if (!tok_in.have_main) begin
                    tok_next.have_main = 1'b1;
                    tok_next.main      = ext_reg;
                end else begin
                    tok_next.have_cow = 1'b1;
                    tok_next.stop     = 1'b1;
                    if (tok_in.main.state == ST_COPY_SOURCE) begin
                        tok_next.cow_start = tok_in.main.start;
                        tok_next.cow_vol   = tok_in.main.vol;
                        tok_next.main      = ext_reg;
                    end else begin
                        tok_next.cow_start = ext_reg.start;
                        tok_next.cow_vol   = ext_reg.vol;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end
    end
endmodule

@@ src/erc_resolve.sv @@
// Route decision at the end of the chain, two registered stages.
// Depends on erc_pkg.
module erc_resolve (
    input  logic            aclk,
    input  logic            aresetn,
    input  erc_pkg::token_t tok,
    output erc_pkg::result_t res
);
    import erc_pkg::*;

    logic        s1_valid_reg;
    logic [2:0]  s1_route_reg;
    logic [53:0] s1_start_reg;
    logic [53:0] s1_vol_reg;
    logic [53:0] s1_sect_reg;
    logic [2:0]  route_next;
    logic [53:0] start_next;
    logic [53:0] vol_next;
    logic [53:0] diff;
    logic [53:0] page;
    logic        hole;
    logic        len_ok;
    logic [63:0] dev_next;
    result_t     res_reg;

    // Hole test, length check and choice of the extent to read.
    always_comb begin
        diff   = tok.sect - tok.main.start;
        page   = diff >> PAGE_SHIFT;
        len_ok = {31'd0, tok.cnt} <= {1'b0, tok.main.len, 9'd0};
        if (tok.main.state == ST_INVALID || tok.main.state == ST_NONE) begin
            hole = 1'b1;
        end else if (tok.main.state == ST_NEEDS_INIT) begin
            hole = (page < 54'd32) ? tok.main.init_map[page[4:0]] : 1'b0;
        end else begin
            hole = 1'b0;
        end
        start_next = tok.main.start;
        vol_next   = tok.main.vol;
        if (!tok.have_main || !len_ok) begin
            route_next = ROUTE_FALLBACK;
        end else if (hole && !tok.have_cow) begin
            route_next = ROUTE_ZERO;
        end else begin
            route_next = ROUTE_DEVICE;
            if (hole) begin
                start_next = tok.cow_start;
                vol_next   = tok.cow_vol;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= tok.valid;
        end
        s1_route_reg <= route_next;
        s1_start_reg <= start_next;
        s1_vol_reg   <= vol_next;
        s1_sect_reg  <= tok.sect;
    end

    // Device sector, modulo 2^64.
    always_comb begin
        if (s1_route_reg == ROUTE_DEVICE) begin
            dev_next = {10'd0, s1_sect_reg} - {10'd0, s1_start_reg} + {10'd0, s1_vol_reg};
        end else begin
            dev_next = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else begin
            res_reg.valid <= s1_valid_reg;
        end
        res_reg.route <= s1_route_reg;
        res_reg.dev   <= dev_next;
    end

    assign res = res_reg;
endmodule

@@ src/extent_read_router_core.sv @@
// Top level of the extent read router: control, chain of extent cells
// and route resolver. Depends on erc_pkg, erc_cell and erc_resolve.
//
// Usage:
// One request channel (s_*) carries a command: append an extent, clear the
// table, or route a read. One result channel (m_*) returns exactly one
// route and device sector for every request, in order.
// Appends, clears, unused modes and multi-request reads skip the chain;
// their result goes from the pending registers into the output register.
// A table read is registered at launch, walks the chain of MAX_EXTENTS cells,
// one cell per cycle, then passes two resolve stages and the pending registers.
// One request is worked on at a time; a new request is accepted as soon
// as the previous result sits in the output register, even while the
// receiver stalls. A stalled output holds its result; a finished walk
// waits until the output register is free.
// Reset empties the table (entry count zero) and clears all valid flags;
// entries are stored without reset and are read only after being written.
`include "extent_read_router_core_macros.svh"
module extent_read_router_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [53:0] s_ext_file_sector,
    input  logic [53:0] s_ext_length,
    input  logic [53:0] s_ext_volume_sector,
    input  logic [2:0]  s_ext_state,
    input  logic [31:0] s_ext_init_map,
    input  logic [62:0] s_byte_offset,
    input  logic [31:0] s_byte_count,
    input  logic        s_multi_request,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_route,
    output logic [63:0] m_device_sector
);
    import erc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    token_t            launch_reg, launch_next;
    logic [2:0]        pend_route_reg, pend_route_next;
    logic [63:0]       pend_dev_reg, pend_dev_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_route_reg, m_route_next;
    logic [63:0]       m_dev_reg, m_dev_next;
    logic              accept;
    logic              append_wr;
    ext_t              wr_ext;
    token_t            chain [MAX_EXTENTS+1];
    result_t           res;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign append_wr = accept && (s_mode == MODE_APPEND) && (count_reg < CNT_W'(MAX_EXTENTS));

    assign wr_ext.start    = s_ext_file_sector;
    assign wr_ext.len      = s_ext_length;
    assign wr_ext.vol      = s_ext_volume_sector;
    assign wr_ext.state    = s_ext_state;
    assign wr_ext.init_map = s_ext_init_map;

    // Chain of extent cells.
    assign chain[0] = launch_reg;
    for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
        erc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx     (CNT_W'(i)),
            .count   (count_reg),
            .wr_en   (append_wr && (count_reg == CNT_W'(i))),
            .wr_ext  (wr_ext),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    erc_resolve u_resolve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok     (chain[MAX_EXTENTS]),
        .res     (res)
    );

    // Control: accept a request, run the walk, hand over to the output.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        launch_next     = launch_reg;
        launch_next.valid = 1'b0;
        pend_route_next = pend_route_reg;
        pend_dev_next   = pend_dev_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_route_next    = m_route_reg;
        m_dev_next      = m_dev_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_dev_next = 64'd0;
                    state_next    = ST_DONE;
                    if (s_mode == MODE_APPEND) begin
                        if (append_wr) begin
                            count_next      = count_reg + CNT_W'(1);
                            pend_route_next = ROUTE_DONE;
                        end else begin
                            pend_route_next = ROUTE_FULL;
                        end
                    end else if (s_mode == MODE_CLEAR) begin
                        count_next      = '0;
                        pend_route_next = ROUTE_DONE;
                    end else if (s_mode == MODE_READ) begin
                        if (s_multi_request) begin
                            pend_route_next = ROUTE_FALLBACK;
                        end else begin
                            launch_next           = '0;
                            launch_next.valid     = 1'b1;
                            launch_next.sect      = s_byte_offset[62:9];
                            launch_next.cnt       = {1'b0, s_byte_count}
                                                  + {24'd0, s_byte_offset[8:0]};
                            state_next            = ST_WALK;
                        end
                    end else begin
                        pend_route_next = ROUTE_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (res.valid) begin
                    pend_route_next = res.route;
                    pend_dev_next   = res.dev;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_route_next = pend_route_reg;
                    m_dev_next   = pend_dev_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            m_valid_reg      <= 1'b0;
            launch_reg.valid <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            m_valid_reg      <= m_valid_next;
            launch_reg.valid <= launch_next.valid;
        end
        launch_reg.stop      <= launch_next.stop;
        launch_reg.have_main <= launch_next.have_main;
        launch_reg.have_cow  <= launch_next.have_cow;
        launch_reg.sect      <= launch_next.sect;
        launch_reg.cnt       <= launch_next.cnt;
        launch_reg.main      <= launch_next.main;
        launch_reg.cow_start <= launch_next.cow_start;
        launch_reg.cow_vol   <= launch_next.cow_vol;
        pend_route_reg       <= pend_route_next;
        pend_dev_reg         <= pend_dev_next;
        m_route_reg          <= m_route_next;
        m_dev_reg            <= m_dev_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_route         = m_route_reg;
    assign m_device_sector = m_dev_reg;

    // Checks on the table fill, the walk timing and the result payload.
    `ERC_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(MAX_EXTENTS), "entry count beyond table size")
    `ERC_ASSERT_IMP(a_res_in_walk, aclk, aresetn, res.valid, state_reg == ST_WALK, "route result outside a walk")
    `ERC_ASSERT_IMP(a_dev_zero, aclk, aresetn, m_valid && (m_route != ROUTE_DEVICE), m_device_sector == 64'd0, "device sector set on a non-device route")
endmodule
